@@ sv/pmsec_pkg.sv @@
// Shared types and constants for the two-dimensional parity checker.
`timescale 1ns / 1ps
package pmsec_pkg;

  localparam int unsigned SIZE_W    = 7;  // matrix_size register width
  localparam int unsigned POS_OUT_W = 7;  // error_row / error_column width
  localparam int unsigned VERDICT_W = 2;
  localparam int unsigned CFG_DW    = 32;
  localparam int unsigned CFG_AW    = 1;

  localparam logic [CFG_AW-1:0] REG_MATRIX_SIZE = 1'b0;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_OK      = 2'd0,
    VERDICT_FIX     = 2'd1,
    VERDICT_CORRUPT = 2'd2
  } verdict_t;

  // Control word of the update stage.
  typedef struct packed {
    logic vld;
    logic data_bit;
    logic first_row;
    logic end_row;
    logic end_mat;
  } step_t;

  typedef struct packed {
    verdict_t               verdict;
    logic [POS_OUT_W-1:0]   error_row;
    logic [POS_OUT_W-1:0]   error_column;
  } result_t;

endpackage

@@ sv/pmsec_if.sv @@
// Valid/ready channel interfaces for the input bits and the verdicts.
`timescale 1ns / 1ps
interface pmsec_in_if;
  logic valid;
  logic ready;
  logic data_bit;

  modport source (output valid, output data_bit, input ready);
  modport sink   (input valid, input data_bit, output ready);
endinterface

interface pmsec_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [6:0] error_row;
  logic [6:0] error_column;

  modport source (output valid, output verdict, output error_row, output error_column,
                  input ready);
  modport sink   (input valid, input verdict, input error_row, input error_column,
                  output ready);
endinterface

@@ sv/parity_matrix_single_error_check_top.sv @@
// Top level of the two-dimensional parity checker with single-bit correction.
`timescale 1ns / 1ps
// Feed the bits of a square 0/1 matrix, row-major, one bit per input beat; after
// the last bit of each matrix one result beat gives the verdict (ok, single bit
// to change, corrupt) and, for a single-bit error, its 1-based row and column.
// The block takes one bit per clock, matrix boundaries included, unless the last
// bit of a matrix is held off for want of a queue slot: each bit is a read of its
// column's parity from the column memory in the issue cycle and a write-back in the
// next. Two verdicts can wait in the output queue before the last bit of a
// further matrix is held off. matrix_size (register 0, byte address 0, 7 bits,
// reset 1) sets rows and columns; 0 acts as 1, values above MAX_SIZE act as
// MAX_SIZE. Writing it restarts the matrix; write it only while idle.
// No clearing pass after reset: the first row of every matrix overwrites the
// column memory.
module parity_matrix_single_error_check_top import pmsec_pkg::*; #(
  parameter int unsigned MAX_SIZE = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  pmsec_in_if.sink          in_ch,
  pmsec_out_if.source       out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

  logic              cfg_wr;
  logic [SIZE_W-1:0] matrix_size;
  logic              slot_free;
  logic              accept;
  logic [IW-1:0]     rd_addr;
  step_t             step;
  logic [IW-1:0]     step_col, step_row;
  logic              rd_parity;
  logic              wr_en, wr_parity;
  logic [IW-1:0]     wr_addr;
  logic              push, pop;
  result_t           result, head;
  logic              head_valid;
  logic [1:0]        q_count;

  // APB: zero-wait; writes land on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_MATRIX_SIZE);
  assign prdata = (paddr == REG_MATRIX_SIZE) ? CFG_DW'(matrix_size) : '0;

  // Last bit of a matrix only enters when a queue slot is sure to be free:
  // queued verdicts plus one in the update stage, less one leaving now.
  assign pop       = out_ch.valid && out_ch.ready;
  assign slot_free = ({1'b0, q_count} + {2'b00, step.vld && step.end_mat})
                     < (3'd2 + {2'b00, pop});

  pmsec_ctrl #(.MAX_SIZE(MAX_SIZE), .IW(IW)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr      (cfg_wr),
    .cfg_size    (pwdata[SIZE_W-1:0]),
    .matrix_size (matrix_size),
    .in_valid    (in_ch.valid),
    .in_data     (in_ch.data_bit),
    .in_ready    (in_ch.ready),
    .slot_free   (slot_free),
    .accept      (accept),
    .rd_addr     (rd_addr),
    .step        (step),
    .step_col    (step_col),
    .step_row    (step_row)
  );

  pmsec_colmem #(.MAX_SIZE(MAX_SIZE), .IW(IW)) u_colmem (
    .clk   (clk),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_parity),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_parity)
  );

  pmsec_accum #(.MAX_SIZE(MAX_SIZE), .IW(IW)) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (cfg_wr),
    .step      (step),
    .step_col  (step_col),
    .step_row  (step_row),
    .rd_parity (rd_parity),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_parity (wr_parity),
    .push      (push),
    .result    (result)
  );

  pmsec_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (result),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (q_count)
  );

  assign out_ch.valid        = head_valid;
  assign out_ch.verdict      = head.verdict;
  assign out_ch.error_row    = head.error_row;
  assign out_ch.error_column = head.error_column;

endmodule

@@ sv/pmsec_colmem.sv @@
// Column parity memory: one bit per column, one write and one registered read port.
`timescale 1ns / 1ps
module pmsec_colmem #(
  parameter int unsigned MAX_SIZE = 64,
  parameter int unsigned IW       = 6
) (
  input  logic          clk,
  input  logic          re,
  input  logic [IW-1:0] raddr,
  output logic          rdata,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic          wdata
);

  logic mem [MAX_SIZE];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/pmsec_ctrl.sv @@
// Size register, row/column sequencer and issue stage for the column memory.
`timescale 1ns / 1ps
module pmsec_ctrl import pmsec_pkg::*; #(
  parameter int unsigned MAX_SIZE = 64,
  parameter int unsigned IW       = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr,
  input  logic [SIZE_W-1:0] cfg_size,
  output logic [SIZE_W-1:0] matrix_size,
  input  logic              in_valid,
  input  logic              in_data,
  output logic              in_ready,
  input  logic              slot_free,
  output logic              accept,
  output logic [IW-1:0]     rd_addr,
  output step_t             step,
  output logic [IW-1:0]     step_col,
  output logic [IW-1:0]     step_row
);

  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [IW-1:0]     col_r, col_nxt;
  logic [IW-1:0]     row_r, row_nxt;
  step_t             step_r, step_nxt;
  logic [IW-1:0]     scol_r, srow_r;
  logic [8:0]        size_eff;
  logic [IW-1:0]     last_idx;
  logic              end_row, end_mat;

  // zero counts as one, oversize clamps to the memory depth
  always_comb begin
    if (size_r == '0) begin
      size_eff = 9'd1;
    end else if ({2'b00, size_r} > 9'(MAX_SIZE)) begin
      size_eff = 9'(MAX_SIZE);
    end else begin
      size_eff = {2'b00, size_r};
    end
  end

  assign last_idx = IW'(size_eff - 9'd1);
  assign end_row  = (col_r == last_idx);
  assign end_mat  = end_row && (row_r == last_idx);
  assign in_ready = !end_mat || slot_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    size_nxt = size_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    step_nxt = '0;
    if (cfg_wr) begin
      size_nxt = cfg_size;
      col_nxt  = '0;
      row_nxt  = '0;
    end else if (accept) begin
      step_nxt.vld       = 1'b1;
      step_nxt.data_bit  = in_data;
      step_nxt.first_row = (row_r == '0);
      step_nxt.end_row   = end_row;
      step_nxt.end_mat   = end_mat;
      col_nxt = end_row ? '0 : col_r + IW'(1);
      if (end_row) begin
        row_nxt = end_mat ? '0 : row_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_W'(1);
      col_r  <= '0;
      row_r  <= '0;
      step_r <= '0;
    end else begin
      size_r <= size_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scol_r <= col_r;
      srow_r <= row_r;
    end
  end

  assign matrix_size = size_r;
  assign rd_addr     = col_r;
  assign step        = step_r;
  assign step_col    = scol_r;
  assign step_row    = srow_r;

  // a later-row read never meets the write still in flight to the same column
  a_no_raw_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && step_r.vld && (row_r != '0)) |-> (col_r != scol_r))
    else $error("column read overlaps pending write");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (col_r == '0) && (row_r == '0))
    else $error("size write did not restart the matrix");

endmodule

@@ sv/pmsec_accum.sv @@
// Update stage: column parity read-modify-write, odd row/column tallies, verdict.
`timescale 1ns / 1ps
module pmsec_accum import pmsec_pkg::*; #(
  parameter int unsigned MAX_SIZE = 64,
  parameter int unsigned IW       = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clear,
  input  step_t         step,
  input  logic [IW-1:0] step_col,
  input  logic [IW-1:0] step_row,
  input  logic          rd_parity,
  output logic          wr_en,
  output logic [IW-1:0] wr_addr,
  output logic          wr_parity,
  output logic          push,
  output result_t       result
);

  localparam int unsigned CW = $clog2(MAX_SIZE + 1);

  logic          rowpar_r, rowpar_nxt;
  logic [1:0]    orc_r, orc_nxt;
  logic [IW-1:0] ori_r, ori_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [IW-1:0] oxor_r, oxor_nxt;
  logic          par_new;

  // first row of a matrix overwrites whatever the memory held
  assign par_new   = (step.first_row ? 1'b0 : rd_parity) ^ step.data_bit;
  assign wr_en     = step.vld;
  assign wr_addr   = step_col;
  assign wr_parity = par_new;
  assign push      = step.vld && step.end_mat;

  always_comb begin
    rowpar_nxt = rowpar_r;
    orc_nxt    = orc_r;
    ori_nxt    = ori_r;
    occ_nxt    = occ_r;
    oxor_nxt   = oxor_r;
    if (step.vld && step.data_bit) begin
      rowpar_nxt = ~rowpar_r;
      oxor_nxt   = oxor_r ^ step_col;
      if (par_new) begin
        occ_nxt = occ_r + CW'(1);
      end else if (occ_r != '0) begin
        occ_nxt = occ_r - CW'(1);
      end
    end
    if (step.vld && step.end_row) begin
      if (rowpar_nxt) begin
        if (orc_r != 2'd2) begin
          orc_nxt = orc_r + 2'd1;
        end
        ori_nxt = step_row;
      end
      rowpar_nxt = 1'b0;
    end
  end

  always_comb begin
    result = '{verdict: VERDICT_CORRUPT, error_row: '0, error_column: '0};
    if ((orc_nxt == 2'd0) && (occ_nxt == '0)) begin
      result.verdict = VERDICT_OK;
    end else if ((orc_nxt == 2'd1) && (occ_nxt == CW'(1))) begin
      result.verdict      = VERDICT_FIX;
      result.error_row    = POS_OUT_W'(ori_nxt) + POS_OUT_W'(1);
      result.error_column = POS_OUT_W'(oxor_nxt) + POS_OUT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear || push) begin
      rowpar_r <= 1'b0;
      orc_r    <= '0;
      ori_r    <= '0;
      occ_r    <= '0;
      oxor_r   <= '0;
    end else begin
      rowpar_r <= rowpar_nxt;
      orc_r    <= orc_nxt;
      ori_r    <= ori_nxt;
      occ_r    <= occ_nxt;
      oxor_r   <= oxor_nxt;
    end
  end

  a_fix_has_position: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (result.verdict == VERDICT_FIX)) |->
      (result.error_row != '0) && (result.error_column != '0))
    else $error("single-bit verdict without a position");

endmodule

@@ sv/pmsec_outq.sv @@
// Two-entry verdict queue between the update stage and the result channel.
`timescale 1ns / 1ps
module pmsec_outq import pmsec_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  result_t    push_data,
  input  logic       pop,
  output logic       head_valid,
  output result_t    head,
  output logic [1:0] count
);

  result_t    slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop  ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head       = slot_r[rptr_r];
  assign count      = cnt_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> (!push || pop))
    else $error("verdict queue overflow");

endmodule
